// ===== hdl/ptsr_pkg.sv =====
// shared types, constants and the sine table for the point transform unit
`default_nettype none

package ptsr_pkg;

   // transform selection held in the mode register
   typedef enum logic [1:0] {
      MODE_TRANSLATE = 2'd0,
      MODE_SCALE     = 2'd1,
      MODE_ROTATE    = 2'd2,
      MODE_PASS      = 2'd3
   } mode_type;

   // control register indexes on the csr channel
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MODE    = 2'd0,
      CSR_PARAM_A = 2'd1,
      CSR_PARAM_B = 2'd2
   } csr_index_type;

   // angle reduction: a + 92*360 is non-negative, then divide by 360 via reciprocal
   localparam logic [16:0] ANGLE_OFFSET = 17'd33120;
   localparam logic [11:0] RECIP_360    = 12'd2912;
   localparam int          RECIP_SHIFT  = 20;
   localparam logic [9:0]  DEG_FULL     = 10'd360;
   localparam logic [8:0]  DEG_90       = 9'd90;
   localparam logic [8:0]  DEG_180      = 9'd180;
   localparam logic [8:0]  DEG_270      = 9'd270;

   // q1.15 fraction bits of the sine table
   localparam int Q15_FRAC_BITS = 15;

   // round(sin(d) * 2^15) for d = 0..90 degrees
   localparam logic [15:0] SINE_Q15 [0:90] = '{
          16'd0,   16'd572,  16'd1144,  16'd1715,  16'd2286,
       16'd2856,  16'd3425,  16'd3993,  16'd4560,  16'd5126,
       16'd5690,  16'd6252,  16'd6813,  16'd7371,  16'd7927,
       16'd8481,  16'd9032,  16'd9580, 16'd10126, 16'd10668,
      16'd11207, 16'd11743, 16'd12275, 16'd12803, 16'd13328,
      16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
      16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
      16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622,
      16'd21063, 16'd21498, 16'd21926, 16'd22348, 16'd22763,
      16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730,
      16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510,
      16'd26842, 16'd27166, 16'd27482, 16'd27789, 16'd28088,
      16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
      16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
      16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499,
      16'd31651, 16'd31795, 16'd31928, 16'd32052, 16'd32166,
      16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588,
      16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763,
      16'd32768
   };

endpackage

`default_nettype wire

// ===== hdl/ptsr_if.sv =====
// channel interfaces: vertex request, transformed result and register writes
`default_nettype none

interface ptsr_req_if #(parameter int COORD_WIDTH = 16) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] x_in;
   logic signed [COORD_WIDTH-1:0] y_in;

   modport source (output valid, output x_in, output y_in, input ready);
   modport sink   (input valid, input x_in, input y_in, output ready);
endinterface

interface ptsr_rsp_if #(parameter int COORD_WIDTH = 16) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] x_out;
   logic signed [COORD_WIDTH-1:0] y_out;
   logic                          saturated;

   modport source (output valid, output x_out, output y_out, output saturated, input ready);
   modport sink   (input valid, input x_out, input y_out, input saturated, output ready);
endinterface

interface ptsr_csr_if import ptsr_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/point_translate_scale_rotate_unit.sv =====
// top level: seven-stage pipelined 2d vertex translate / scale / rotate unit
//
// channels: req carries one vertex (x_in, y_in) per transfer, rsp returns the
// transformed vertex (x_out, y_out) with a saturated flag, csr writes the mode,
// parameter_a and parameter_b registers (index 0, 1, 2; other indexes ignored).
// csr is always ready and is to be written only while no vertex is in flight.
// every accepted vertex yields exactly one result, in order.
// throughput: one vertex per cycle unless rsp stalls; the stages are angle
// reciprocal multiply, remainder by 360, quadrant and sine table, four
// coordinate multipliers, sums, q15 truncation, and clamping into the output
// register.
// when a result waits in the output register and rsp is stalled, the whole
// pipeline holds and req.ready drops; otherwise every stage advances each cycle.
// reset (synchronous) empties the pipeline and sets all three registers to 0.
`default_nettype none

module point_translate_scale_rotate_unit
   import ptsr_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ptsr_req_if.sink    req,
   ptsr_rsp_if.source  rsp,
   ptsr_csr_if.sink    csr
);

   localparam int W  = COORD_WIDTH;
   localparam int MW = COORD_WIDTH + 17;
   localparam int SW = COORD_WIDTH + 18;
   localparam logic signed [SW-1:0] COORD_MAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [SW-1:0] COORD_MIN = ~COORD_MAX;
   localparam logic signed [SW-1:0] TRUNC_BIAS = SW'((1 << Q15_FRAC_BITS) - 1);

   // control registers
   mode_type                   mode_ff;
   logic signed [15:0]         param_a_ff;
   logic signed [15:0]         param_b_ff;

   // pipeline advance: move when the output slot is empty or being taken
   logic                       adv;
   logic                       rsp_valid_ff;

   assign adv       = !rsp_valid_ff || rsp.ready;
   assign req.ready = adv;
   assign csr.ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_TRANSLATE;
         param_a_ff <= '0;
         param_b_ff <= '0;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_MODE:    mode_ff    <= mode_type'(csr.data[1:0]);
            CSR_PARAM_A: param_a_ff <= csr.data;
            CSR_PARAM_B: param_b_ff <= csr.data;
            default:     ;
         endcase
      end
   end

   // offset angle and reciprocal quotient estimate
   logic [16:0]         angle_ofs;
   logic [28:0]         quot_prod;
   logic                v1_ff;
   logic signed [W-1:0] x1_ff, y1_ff;
   logic [7:0]          q1_ff;

   assign angle_ofs = {param_a_ff[15], param_a_ff} + ANGLE_OFFSET;
   assign quot_prod = 29'(angle_ofs) * 29'(RECIP_360);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x1_ff <= req.x_in;
         y1_ff <= req.y_in;
         q1_ff <= quot_prod[RECIP_SHIFT +: 8];
      end
   end

   // remainder by 360 with one correction step
   logic [16:0]         rem_full;
   logic [9:0]          rem_est;
   logic [8:0]          d2_in;
   logic                v2_ff;
   logic signed [W-1:0] x2_ff, y2_ff;
   logic [8:0]          d2_ff;

   assign rem_full = angle_ofs - 17'(q1_ff * 17'(DEG_FULL));
   assign rem_est  = rem_full[9:0];

   always_comb begin
      if (rem_est >= DEG_FULL) begin
         d2_in = 9'(rem_est - DEG_FULL);
      end else begin
         d2_in = rem_est[8:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x2_ff <= x1_ff;
         y2_ff <= y1_ff;
         d2_ff <= d2_in;
      end
   end

   // quadrant split and sine table lookup
   logic [1:0]          quad;
   logic [8:0]          rem_deg;
   logic [6:0]          tab_lo, tab_hi;
   logic signed [16:0]  sin_pos, cos_pos;
   logic signed [16:0]  sin3_in, cos3_in;
   logic                v3_ff;
   logic signed [W-1:0] x3_ff, y3_ff;
   logic signed [16:0]  sin3_ff, cos3_ff;

   always_comb begin
      priority if (d2_ff >= DEG_270) begin
         quad    = 2'd3;
         rem_deg = d2_ff - DEG_270;
      end else if (d2_ff >= DEG_180) begin
         quad    = 2'd2;
         rem_deg = d2_ff - DEG_180;
      end else if (d2_ff >= DEG_90) begin
         quad    = 2'd1;
         rem_deg = d2_ff - DEG_90;
      end else begin
         quad    = 2'd0;
         rem_deg = d2_ff;
      end
   end

   assign tab_lo  = rem_deg[6:0];
   assign tab_hi  = 7'(DEG_90 - rem_deg);
   assign sin_pos = $signed({1'b0, SINE_Q15[tab_lo]});
   assign cos_pos = $signed({1'b0, SINE_Q15[tab_hi]});

   always_comb begin
      unique case (quad)
         2'd0: begin sin3_in =  sin_pos; cos3_in =  cos_pos; end
         2'd1: begin sin3_in =  cos_pos; cos3_in = -sin_pos; end
         2'd2: begin sin3_in = -sin_pos; cos3_in = -cos_pos; end
         default: begin sin3_in = -cos_pos; cos3_in =  sin_pos; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x3_ff   <= x2_ff;
         y3_ff   <= y2_ff;
         sin3_ff <= sin3_in;
         cos3_ff <= cos3_in;
      end
   end

   // four multipliers, shared between scale and rotate
   logic signed [16:0]   op_x, op_y;
   logic                 v4_ff;
   logic signed [W-1:0]  x4_ff, y4_ff;
   logic signed [MW-1:0] p0_ff, p1_ff, p2_ff, p3_ff;

   assign op_x = (mode_ff == MODE_SCALE) ? 17'(param_a_ff) : cos3_ff;
   assign op_y = (mode_ff == MODE_SCALE) ? 17'(param_b_ff) : cos3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x4_ff <= x3_ff;
         y4_ff <= y3_ff;
         p0_ff <= MW'(x3_ff) * MW'(op_x);
         p1_ff <= MW'(y3_ff) * MW'(sin3_ff);
         p2_ff <= MW'(x3_ff) * MW'(sin3_ff);
         p3_ff <= MW'(y3_ff) * MW'(op_y);
      end
   end

   // per-mode wide result before truncation
   logic signed [SW-1:0] sx5_in, sy5_in;
   logic                 v5_ff;
   logic signed [SW-1:0] sx5_ff, sy5_ff;

   always_comb begin
      unique case (mode_ff)
         MODE_TRANSLATE: begin
            sx5_in = SW'(x4_ff) + SW'(param_a_ff);
            sy5_in = SW'(y4_ff) + SW'(param_b_ff);
         end
         MODE_SCALE: begin
            sx5_in = SW'(p0_ff);
            sy5_in = SW'(p3_ff);
         end
         MODE_ROTATE: begin
            sx5_in = SW'(p0_ff) - SW'(p1_ff);
            sy5_in = SW'(p2_ff) + SW'(p3_ff);
         end
         MODE_PASS: begin
            sx5_in = SW'(x4_ff);
            sy5_in = SW'(y4_ff);
         end
         default: begin
            sx5_in = SW'(x4_ff);
            sy5_in = SW'(y4_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sx5_ff <= sx5_in;
         sy5_ff <= sy5_in;
      end
   end

   // q15 division truncated toward zero, rotate only
   logic signed [SW-1:0] tx6_in, ty6_in;
   logic                 v6_ff;
   logic signed [SW-1:0] tx6_ff, ty6_ff;

   always_comb begin
      if (mode_ff == MODE_ROTATE) begin
         tx6_in = $signed(sx5_ff + (sx5_ff[SW-1] ? TRUNC_BIAS : '0)) >>> Q15_FRAC_BITS;
         ty6_in = $signed(sy5_ff + (sy5_ff[SW-1] ? TRUNC_BIAS : '0)) >>> Q15_FRAC_BITS;
      end else begin
         tx6_in = sx5_ff;
         ty6_in = sy5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (adv) begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tx6_ff <= tx6_in;
         ty6_ff <= ty6_in;
      end
   end

   // clamp into coordinate range and output register
   logic signed [W-1:0] x_out_in, y_out_in;
   logic                x_hit, y_hit;
   logic signed [W-1:0] x_out_ff, y_out_ff;
   logic                sat_ff;

   always_comb begin
      x_hit = 1'b1;
      y_hit = 1'b1;
      priority if (tx6_ff > COORD_MAX) begin
         x_out_in = COORD_MAX[W-1:0];
      end else if (tx6_ff < COORD_MIN) begin
         x_out_in = COORD_MIN[W-1:0];
      end else begin
         x_out_in = tx6_ff[W-1:0];
         x_hit    = 1'b0;
      end
      priority if (ty6_ff > COORD_MAX) begin
         y_out_in = COORD_MAX[W-1:0];
      end else if (ty6_ff < COORD_MIN) begin
         y_out_in = COORD_MIN[W-1:0];
      end else begin
         y_out_in = ty6_ff[W-1:0];
         y_hit    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_out_ff <= x_out_in;
         y_out_ff <= y_out_in;
         sat_ff   <= x_hit || y_hit;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.x_out     = x_out_ff;
   assign rsp.y_out     = y_out_ff;
   assign rsp.saturated = sat_ff;

   // reduced angle always lands in 0..359
   assert property (@(posedge clock) disable iff (reset) v2_ff |-> (d2_ff < 9'd360))
      else $error("angle remainder out of range");

   // a request transfer always fills the first stage
   assert property (@(posedge clock) disable iff (reset) (req.valid && req.ready) |=> v1_ff)
      else $error("accepted vertex lost at stage one");

   // reset empties the pipeline
   assert property (@(posedge clock) reset |=> (!v1_ff && !v4_ff && !rsp_valid_ff))
      else $error("pipeline not empty after reset");

   // pass-through mode never clips
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && mode_ff == MODE_PASS) |-> !sat_ff)
      else $error("saturation flagged in pass-through mode");

endmodule

`default_nettype wire
